// ----- design/tce_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tce_pkg: shared types and constants of the transitive closure engine
// Item layouts, cell control group and fixed field widths.
// ----------------------------------------------------------------------------
package tce_pkg;

	localparam int NODE_W = 4;
	localparam int CNT_W = 5;
	localparam int ROW_W = 16;
	localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 5'd16;

	typedef struct packed {
		logic [NODE_W-1:0] source_node;
		logic [NODE_W-1:0] target_node;
		logic              has_edge;
		logic              last_edge;
	} in_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] row_index;
		logic [ROW_W-1:0]  reach_row;
		logic              last_row;
	} out_item_t;

	typedef struct packed {
		logic write;
		logic shift;
		logic pivot;
		logic clear;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- design/tce_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tce_cell: one row cell of the closure chain
// Holds one adjacency row, sets edge bits, applies the pivot update and
// passes its updated row to its neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module tce_cell #(
	parameter int W = 16,
	parameter int IDX_W = 4,
	parameter int INDEX = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tce_pkg::cell_ctrl_t ctrl,
	input  wire logic [IDX_W-1:0]    src_idx,
	input  wire logic [IDX_W-1:0]    dst_idx,
	input  wire logic [IDX_W-1:0]    pivot_idx,
	input  wire logic [W-1:0]        head_row,
	input  wire logic [W-1:0]        nbr_row,
	output logic [W-1:0]             upd_row,
	output logic [W-1:0]             row
);

	logic [W-1:0] row_q;

	assign upd_row = (ctrl.pivot && row_q[pivot_idx]) ? (row_q | head_row) : row_q;
	assign row = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctrl.clear) begin
			row_q <= '0;
		end else if (ctrl.shift) begin
			row_q <= nbr_row;
		end else if (ctrl.write && (src_idx == IDX_W'(INDEX))) begin
			row_q <= row_q | (W'(1) << dst_idx);
		end
	end

endmodule
`default_nettype wire

// ----- design/transitive_closure_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// transitive_closure_engine: Warshall transitive closure over a bit matrix
// Edges arrive one item per cycle on the input channel (in_valid/in_ready,
// payload in_data) and set one bit of a row held in a chain of row cells.
// An edge whose source or target is not below min(node count, MAX_NODES, 16) is dropped.
// The item marked last_edge ends the set. The rows then rotate once around
// the cell ring, one pivot per cycle. Next the chain drains one row per
// cycle, while the receiver takes every item, into the output register
// (out_valid/out_ready, payload out_data), node 0 first, with last_row on the
// final row; one row goes out per node in use (the node count, at most
// min(MAX_NODES,16)). The first row is registered at the output once the
// rotation ends and the output register is free. A stalled receiver holds
// the output register and freezes the drain. After the final row is loaded
// the store is cleared and input is taken again at once, while that row may
// still wait at the output. A zero node count emits nothing and only clears
// the store. Input is not taken during closure or drain. The node count is
// written on cfg_we with cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this. Reset clears the
// store, sets the node count to 16 and empties the output register.
// ----------------------------------------------------------------------------
module transitive_closure_engine #(
	parameter int MAX_NODES = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire tce_pkg::in_item_t                  in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output tce_pkg::out_item_t                      out_data,
	input  wire logic                               cfg_we,
	input  wire logic [tce_pkg::CNT_W-1:0]          cfg_wdata
);

	localparam int ROWS = (MAX_NODES < tce_pkg::ROW_W) ? MAX_NODES : tce_pkg::ROW_W;
	localparam int IDX_W = $clog2(ROWS);
	localparam logic [tce_pkg::CNT_W-1:0] ROWS_C = tce_pkg::CNT_W'(ROWS);
	localparam logic [tce_pkg::CNT_W-1:0] LAST_STEP = tce_pkg::CNT_W'(ROWS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CLOSE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]                    state_q;
	logic [tce_pkg::CNT_W-1:0]     node_count_q;
	logic [tce_pkg::CNT_W-1:0]     step_q;
	logic [tce_pkg::CNT_W-1:0]     n_eff;
	logic                          out_valid_q;
	tce_pkg::out_item_t            out_q;
	tce_pkg::out_item_t            out_d;
	tce_pkg::cell_ctrl_t           ctrl;
	logic                          in_fire;
	logic                          edge_ok;
	logic                          out_free;
	logic                          load_out;
	logic [ROWS-1:0]               mask;
	logic [ROWS-1:0]               upd [ROWS];
	logic [ROWS-1:0]               rows [ROWS];
	logic [ROWS-1:0]               nbr [ROWS];

	assign n_eff = (node_count_q > ROWS_C) ? ROWS_C : node_count_q;
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign edge_ok = in_data.has_edge
		&& ({1'b0, in_data.source_node} < n_eff)
		&& ({1'b0, in_data.target_node} < n_eff);
	assign out_free = !out_valid_q || out_ready;
	assign load_out = (state_q == ST_DRAIN) && out_free;

	always_comb begin
		ctrl.write = in_fire && edge_ok;
		ctrl.shift = (state_q == ST_CLOSE) || load_out;
		ctrl.pivot = (state_q == ST_CLOSE) && (step_q < n_eff);
		ctrl.clear = (in_fire && in_data.last_edge && (n_eff == '0))
			|| (load_out && (step_q == n_eff - 1'b1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= tce_pkg::NODE_COUNT_RESET;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	genvar j;
	generate
		for (j = 0; j < ROWS; j++) begin : g_cell
			assign mask[j] = (tce_pkg::CNT_W'(j) < n_eff);
			if (j < ROWS - 1) begin : g_link
				assign nbr[j] = upd[j+1];
			end else begin : g_wrap
				assign nbr[j] = (state_q == ST_DRAIN) ? '0 : upd[0];
			end
			tce_cell #(
				.W(ROWS),
				.IDX_W(IDX_W),
				.INDEX(j)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(ctrl),
				.src_idx(in_data.source_node[IDX_W-1:0]),
				.dst_idx(in_data.target_node[IDX_W-1:0]),
				.pivot_idx(step_q[IDX_W-1:0]),
				.head_row(rows[0]),
				.nbr_row(nbr[j]),
				.upd_row(upd[j]),
				.row(rows[j])
			);
		end
	endgenerate

	always_comb begin
		out_d.row_index = step_q[tce_pkg::NODE_W-1:0];
		out_d.reach_row = tce_pkg::ROW_W'(rows[0] & mask);
		out_d.last_row = (step_q == n_eff - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && in_data.last_edge && (n_eff != '0)) begin
						state_q <= ST_CLOSE;
						step_q <= '0;
					end
				end
				ST_CLOSE: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_DRAIN;
						step_q <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (load_out) begin
						if (step_q == n_eff - 1'b1) begin
							state_q <= ST_IDLE;
							step_q <= '0;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					step_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef ASSERT_OFF
	a_drain_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (step_q < n_eff))
		else $error("Drain step is beyond the node count.");

	a_close_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE) |-> (step_q <= LAST_STEP))
		else $error("Closure step is beyond the ring length.");

	a_final_row_out: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && out_d.last_row) |=> (out_valid && out_data.last_row
			&& (state_q == ST_IDLE)))
		else $error("Final row was not presented after the drain ended.");

	a_store_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && out_d.last_row) |=> (rows[0] == '0))
		else $error("Store was not cleared at the end of a set.");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/transitive_closure_engine_tb.sv -----
// ----------------------------------------------------------------------------
// transitive_closure_engine_tb: self-checking bench for the closure engine
// Edge sets are sent on the input channel. The bench keeps its own adjacency
// matrix and runs the closure on each item marked last_edge. It queues the
// reach rows it expects and compares each row that the block emits, field by
// field. Node counts at both extremes, zero and saturated values are written
// between sets and once within a set. Both sides idle at random, and some
// stretches run without any idling.
// ----------------------------------------------------------------------------
module transitive_closure_engine_tb;

	localparam int MAX_NODES = 16;
	localparam int SETTLE_CYCLES = 48;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 290;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	tce_pkg::in_item_t            in_data = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	tce_pkg::out_item_t           out_data;
	logic                         cfg_we = 1'b0;
	logic [tce_pkg::CNT_W-1:0]    cfg_wdata = '0;

	logic [tce_pkg::ROW_W-1:0]    adj_rows [MAX_NODES];
	logic [tce_pkg::CNT_W-1:0]    node_count_q = tce_pkg::NODE_COUNT_RESET;
	tce_pkg::out_item_t           expected_rows [$];

	bit                  tx_calm = 1'b0;
	bit                  rx_calm = 1'b0;
	int                  error_count = 0;
	int                  rows_checked = 0;
	int                  sets_closed = 0;
	int                  items_sent = 0;
	int                  counts_written = 0;

	transitive_closure_engine #(
		.MAX_NODES (MAX_NODES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic tce_pkg::in_item_t make_item(input int src, input int dst,
			input bit has_edge, input bit last_edge);
		tce_pkg::in_item_t it;
		it.source_node = src[tce_pkg::NODE_W-1:0];
		it.target_node = dst[tce_pkg::NODE_W-1:0];
		it.has_edge = has_edge;
		it.last_edge = last_edge;
		return it;
	endfunction

	function automatic int nodes_in_use();
		return (node_count_q > MAX_NODES) ? MAX_NODES : int'(node_count_q);
	endfunction

	task automatic close_and_predict(input tce_pkg::in_item_t it);
		int n;
		logic [tce_pkg::ROW_W-1:0] mask;
		tce_pkg::out_item_t row;
		n = nodes_in_use();
		if (it.has_edge && it.source_node < n && it.target_node < n) begin
			adj_rows[it.source_node][it.target_node] = 1'b1;
		end
		if (!it.last_edge) begin
			return;
		end
		mask = (n >= tce_pkg::ROW_W) ? '1 : tce_pkg::ROW_W'((32'd1 << n) - 1);
		for (int i = 0; i < n; i++) begin
			adj_rows[i] &= mask;
		end
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < n; i++) begin
				if (adj_rows[i][k]) begin
					adj_rows[i] |= adj_rows[k];
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			row.row_index = tce_pkg::NODE_W'(i);
			row.reach_row = adj_rows[i];
			row.last_row = (i + 1 == n);
			expected_rows.push_back(row);
		end
		for (int i = 0; i < MAX_NODES; i++) begin
			adj_rows[i] = '0;
		end
		sets_closed++;
	endtask

	task automatic send_item(input tce_pkg::in_item_t it);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		close_and_predict(it);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_node_count(input int value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= tce_pkg::CNT_W'(value);
		@(posedge clk);
		node_count_q = tce_pkg::CNT_W'(value);
		cfg_we <= 1'b0;
		counts_written++;
		@(posedge clk);
	endtask

	initial begin : row_checker
		int stall;
		tce_pkg::out_item_t want;
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			if (expected_rows.size() == 0) begin
				report_mismatch($sformatf("unexpected row %0d reach %h",
					out_data.row_index, out_data.reach_row));
			end else begin
				want = expected_rows.pop_front();
				if (out_data.row_index !== want.row_index) begin
					report_mismatch($sformatf("row_index got %0d want %0d",
						out_data.row_index, want.row_index));
				end
				if (out_data.reach_row !== want.reach_row) begin
					report_mismatch($sformatf("row %0d reach_row got %h want %h",
						want.row_index, out_data.reach_row, want.reach_row));
				end
				if (out_data.last_row !== want.last_row) begin
					report_mismatch($sformatf("row %0d last_row got %b want %b",
						want.row_index, out_data.last_row, want.last_row));
				end
				rows_checked++;
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_ready === 1'b1) ||
					(out_valid === 1'b1 && out_ready === 1'b1)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("watchdog expired with %0d rows outstanding", expected_rows.size());
		$display("[transitive_closure_engine] ERROR");
		$finish;
	end

	task automatic test_reset_count();
		send_item(make_item(0, 15, 1'b1, 1'b0));
		send_item(make_item(15, 0, 1'b1, 1'b0));
		send_item(make_item(7, 7, 1'b0, 1'b0));
		send_item(make_item(5, 5, 1'b1, 1'b1));
	endtask

	task automatic test_single_node();
		write_node_count(1);
		send_item(make_item(0, 0, 1'b1, 1'b0));
		send_item(make_item(1, 0, 1'b1, 1'b0));
		send_item(make_item(0, 5, 1'b1, 1'b0));
		send_item(make_item(0, 0, 1'b0, 1'b1));
	endtask

	task automatic test_zero_nodes();
		write_node_count(0);
		send_item(make_item(2, 3, 1'b1, 1'b0));
		send_item(make_item(0, 0, 1'b1, 1'b1));
	endtask

	task automatic test_saturated_count();
		write_node_count(31);
		send_item(make_item(15, 15, 1'b1, 1'b0));
		send_item(make_item(14, 15, 1'b1, 1'b1));
	endtask

	task automatic test_count_change_in_set();
		write_node_count(16);
		send_item(make_item(1, 2, 1'b1, 1'b0));
		send_item(make_item(12, 13, 1'b1, 1'b0));
		send_item(make_item(13, 1, 1'b1, 1'b0));
		write_node_count(4);
		send_item(make_item(2, 3, 1'b1, 1'b1));
	endtask

	task automatic test_random_sets();
		int budget;
		int edges;
		int n;
		int pick;
		int src;
		int dst;
		budget = 0;
		while (budget < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				case ($urandom_range(0, 5))
					0: write_node_count(0);
					1: write_node_count(1);
					2: write_node_count(16);
					3: write_node_count($urandom_range(17, 31));
					default: write_node_count($urandom_range(2, 15));
				endcase
			end
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			n = nodes_in_use();
			edges = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
			for (int e = 0; e < edges; e++) begin
				if (n > 0 && $urandom_range(0, 99) < 85) begin
					src = $urandom_range(0, n - 1);
					dst = $urandom_range(0, n - 1);
				end else begin
					src = $urandom_range(0, 15);
					dst = $urandom_range(0, 15);
				end
				if ($urandom_range(0, 9) == 0) begin
					send_item(make_item(src, dst, 1'b0, 1'b0));
				end else begin
					send_item(make_item(src, dst, 1'b1, 1'b0));
					budget++;
				end
			end
			send_item(make_item($urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 1), 1'b1));
			budget++;
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	initial begin : stimulus
		for (int i = 0; i < MAX_NODES; i++) begin
			adj_rows[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_count();
		test_single_node();
		test_zero_nodes();
		test_saturated_count();
		test_count_change_in_set();
		test_random_sets();
		wait_drained();
		$display("Sent %0d items in %0d edge sets, wrote the node count %0d times.",
			items_sent, sets_closed, counts_written);
		$display("Checked %0d reach rows, %0d mismatches.", rows_checked, error_count);
		if (error_count == 0) begin
			$display("[transitive_closure_engine] OK");
		end else begin
			$display("[transitive_closure_engine] ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/tce_pkg.sv
design/tce_cell.sv
design/transitive_closure_engine.sv
tb/sv/transitive_closure_engine_tb.sv
